// ===== rtl/doubly_linked_list_engine_core_defines.svh =====
// assertion macros for the doubly linked list engine
`ifndef DOUBLY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DLL_ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define DLL_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ===== rtl/dll_pkg.sv =====
// types and codes shared by the doubly linked list engine
`default_nettype none
package dll_pkg;
    // command codes
    localparam logic [2:0] OP_INS_HEAD  = 3'd0;
    localparam logic [2:0] OP_INS_TAIL  = 3'd1;
    localparam logic [2:0] OP_INS_AFTER = 3'd2;
    localparam logic [2:0] OP_DELETE    = 3'd3;
    localparam logic [2:0] OP_READ_FWD  = 3'd4;
    localparam logic [2:0] OP_READ_REV  = 3'd5;
    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BEYOND   = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    // most results one read gives
    localparam int MAX_RESULTS = 32;
    // input item: opcode, position, value
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] position;
        logic [2:0]         opcode;
    } dll_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/doubly_linked_list_engine_core.sv =====
// top level of the doubly linked list engine
//
// channel  dir  tdata (low bit up)                      tlast
// s_axis   in   opcode[2:0] position[18:3] value[50:19] -
// m_axis   out  status[2:0] element[34:3]               last
//
// insert at head or tail: free-slot search (up to CAPACITY slots tried), then the node is
// written (S_LINK) and its neighbor links patched (S_FIX), then the result.
// insert-after and delete walk the list node by node (read issue, registered data), and
// insert-after then adds the free-slot search.
// reads give one element at a time (read issue, registered data, output), at most MAX_RESULTS.
// s_axis_tready is high only in idle, from the cycle after the final result is taken; a stalled
// result holds the engine in place; reset clears links to empty, no sweep.
`default_nettype none
module doubly_linked_list_engine_core #(
    parameter int CAPACITY = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [55:0] s_axis_tdata,  // opcode, position, value, zero fill
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status, element, zero fill
    output logic        m_axis_tlast
);
    import dll_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);
    localparam int KW = $clog2(MAX_RESULTS);

    // states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FREE  = 4'd1;  // free-slot search
    localparam logic [3:0] S_WALK  = 4'd2;  // issue read of cur
    localparam logic [3:0] S_WDAT  = 4'd3;  // read data of cur
    localparam logic [3:0] S_LINK  = 4'd4;  // write new node
    localparam logic [3:0] S_FIX   = 4'd5;  // patch neighbor link
    localparam logic [3:0] S_DEL1  = 4'd6;  // patch prev and next neighbors
    localparam logic [3:0] S_DEL2  = 4'd7;  // set ok status
    localparam logic [3:0] S_OUT   = 4'd8;  // result waiting
    localparam logic [3:0] S_ROUT  = 4'd9;  // read element waiting

    // node memory, one read port with registered data
    logic [31:0]   val_mem  [CAPACITY];
    logic [LW-1:0] next_mem [CAPACITY];
    logic [LW-1:0] prev_mem [CAPACITY];
    logic [31:0]   rd_val;
    logic [LW-1:0] rd_next, rd_prev;
    logic [IW-1:0] rd_addr;
    logic          rd_en;

    logic [CAPACITY-1:0] used_reg;
    logic [LW-1:0] head_reg, tail_reg, count_reg;
    logic [3:0]    state_reg;
    dll_cmd_t      cmd_reg;
    logic [LW-1:0] cur_reg, slot_reg, nb_reg, pv_reg;
    logic [IW-1:0] scan_reg;
    logic [15:0]   steps_reg;
    logic [KW-1:0] k_reg;
    logic [2:0]    st_reg;
    logic [31:0]   el_reg;
    logic          last_reg;

    // write ports, one per array
    logic          we_val, we_next, we_prev;
    logic [IW-1:0] wa_val, wa_next, wa_prev;
    logic [31:0]   wd_val;
    logic [LW-1:0] wd_next, wd_prev;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_val  <= val_mem[rd_addr];
            rd_next <= next_mem[rd_addr];
            rd_prev <= prev_mem[rd_addr];
        end
        if (we_val)  val_mem[wa_val]   <= wd_val;
        if (we_next) next_mem[wa_next] <= wd_next;
        if (we_prev) prev_mem[wa_prev] <= wd_prev;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT) || (state_reg == S_ROUT);
    assign m_axis_tdata  = {5'd0, el_reg, st_reg};
    assign m_axis_tlast  = last_reg;

    // read-walk direction link
    logic [LW-1:0] walk_nx;
    assign walk_nx = (cmd_reg.opcode == OP_READ_REV) ? rd_prev : rd_next;

    // memory port steering
    always_comb begin
        rd_en = 1'b0; rd_addr = cur_reg[IW-1:0];
        we_val = 1'b0; wa_val = slot_reg[IW-1:0]; wd_val = cmd_reg.value;
        we_next = 1'b0; wa_next = slot_reg[IW-1:0]; wd_next = NIL;
        we_prev = 1'b0; wa_prev = slot_reg[IW-1:0]; wd_prev = NIL;
        case (state_reg)
            S_WALK: rd_en = 1'b1;
            S_LINK: begin
                we_val = 1'b1; we_next = 1'b1; we_prev = 1'b1;
                if (cmd_reg.opcode == OP_INS_HEAD) begin
                    wd_next = head_reg; wd_prev = NIL;
                end else begin
                    // cur is predecessor or NIL, nb_reg its next
                    wd_prev = cur_reg; wd_next = nb_reg;
                end
            end
            S_FIX: begin
                if (cmd_reg.opcode == OP_INS_HEAD) begin
                    we_prev = (head_reg != NIL); wa_prev = head_reg[IW-1:0];
                    wd_prev = slot_reg;
                end else begin
                    we_next = (cur_reg != NIL); wa_next = cur_reg[IW-1:0];
                    wd_next = slot_reg;
                    we_prev = (nb_reg != NIL); wa_prev = nb_reg[IW-1:0];
                    wd_prev = slot_reg;
                end
            end
            S_DEL1: begin
                we_next = (pv_reg != NIL); wa_next = pv_reg[IW-1:0]; wd_next = nb_reg;
                we_prev = (nb_reg != NIL); wa_prev = nb_reg[IW-1:0]; wd_prev = pv_reg;
            end
            default: ;
        endcase
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            count_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (s_axis_tvalid) begin
                    cmd_reg   <= dll_cmd_t'(s_axis_tdata[50:0]);
                    scan_reg  <= '0;
                    steps_reg <= 16'd1;
                    k_reg     <= '0;
                    el_reg    <= '0;
                    last_reg  <= 1'b1;
                    case (s_axis_tdata[2:0])
                        OP_INS_HEAD, OP_INS_TAIL: begin
                            if (count_reg >= NIL) begin
                                st_reg <= ST_FULL; state_reg <= S_OUT;
                            end else state_reg <= S_FREE;
                            cur_reg <= tail_reg; nb_reg <= NIL;
                        end
                        OP_INS_AFTER: begin
                            if (s_axis_tdata[18:3] == 16'd0 || s_axis_tdata[18]
                                || {1'b0, s_axis_tdata[17:3]} > 16'(count_reg)) begin
                                st_reg <= ST_BEYOND; state_reg <= S_OUT;
                            end else if (count_reg >= NIL) begin
                                st_reg <= ST_FULL; state_reg <= S_OUT;
                            end else state_reg <= S_WALK;
                            cur_reg <= head_reg;
                        end
                        OP_DELETE: begin
                            if (head_reg == NIL) begin
                                st_reg <= ST_NOTFOUND; state_reg <= S_OUT;
                            end else state_reg <= S_WALK;
                            cur_reg <= head_reg;
                        end
                        OP_READ_FWD, OP_READ_REV: begin
                            if (head_reg == NIL) begin
                                st_reg <= ST_EMPTY; state_reg <= S_OUT;
                            end else state_reg <= S_WALK;
                            cur_reg <= (s_axis_tdata[2:0] == OP_READ_FWD) ? head_reg
                                                                           : tail_reg;
                        end
                        default: ;
                    endcase
                end
                S_WALK: state_reg <= S_WDAT;
                S_WDAT: begin
                    case (cmd_reg.opcode)
                        OP_INS_AFTER: begin
                            if (steps_reg == cmd_reg.position) begin
                                nb_reg <= rd_next; state_reg <= S_FREE;
                            end else begin
                                cur_reg <= rd_next; steps_reg <= steps_reg + 16'd1;
                                state_reg <= S_WALK;
                            end
                        end
                        OP_DELETE: begin
                            if (rd_val == cmd_reg.value) begin
                                pv_reg <= rd_prev; nb_reg <= rd_next;
                                state_reg <= S_DEL1;
                            end else if (rd_next == NIL) begin
                                st_reg <= ST_NOTFOUND; state_reg <= S_OUT;
                            end else begin
                                cur_reg <= rd_next; state_reg <= S_WALK;
                            end
                        end
                        default: begin
                            st_reg   <= ST_OK;
                            el_reg   <= rd_val;
                            last_reg <= (walk_nx == NIL)
                                        || (k_reg == KW'(MAX_RESULTS - 1));
                            cur_reg  <= walk_nx;
                            state_reg <= S_ROUT;
                        end
                    endcase
                end
                S_FREE: begin
                    if (!used_reg[scan_reg]) begin
                        slot_reg <= LW'(scan_reg);
                        used_reg[scan_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_LINK;
                    end else scan_reg <= scan_reg + 1'b1;
                end
                S_LINK: state_reg <= S_FIX;
                S_FIX: begin
                    if (cmd_reg.opcode == OP_INS_HEAD) begin
                        if (head_reg == NIL) tail_reg <= slot_reg;
                        head_reg <= slot_reg;
                    end else begin
                        if (cur_reg == NIL) head_reg <= slot_reg;
                        if (nb_reg == NIL) tail_reg <= slot_reg;
                    end
                    st_reg <= ST_OK; state_reg <= S_OUT;
                end
                S_DEL1: begin
                    if (pv_reg == NIL) head_reg <= nb_reg;
                    if (nb_reg == NIL) tail_reg <= pv_reg;
                    used_reg[cur_reg[IW-1:0]] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_DEL2;
                end
                S_DEL2: begin
                    st_reg <= ST_OK; state_reg <= S_OUT;
                end
                S_OUT: if (m_axis_tready) state_reg <= S_IDLE;
                S_ROUT: if (m_axis_tready) begin
                    if (last_reg) state_reg <= S_IDLE;
                    else begin
                        k_reg <= k_reg + 1'b1; state_reg <= S_WALK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dll_checker.sv =====
// port-level checker for the doubly linked list engine and its bind
`default_nettype none
`include "doubly_linked_list_engine_core_defines.svh"
module dll_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [55:0] s_axis_tdata,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    import dll_pkg::*;

    // no new command while a result is pending
    `DLL_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    // a stalled result holds
    `DLL_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // non-ok status carries a zero element and last
    `DLL_ASSERT_IMPL(a_status, aclk, aresetn, m_axis_tvalid && m_axis_tdata[2:0] != ST_OK,
        m_axis_tlast && m_axis_tdata[34:3] == 32'd0)
    // accepted known command drops ready next cycle
    `DLL_ASSERT_NEXT(a_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] <= OP_READ_REV, !s_axis_tready)
endmodule

bind doubly_linked_list_engine_core dll_checker u_dll_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
